FILE: design/pidaw_pkg.sv
// ----------------------------------------------------------------------------
// pidaw_pkg: shared types, widths and arithmetic helpers for the PID block
// Register indexes, reset values and Q16 rounding / clamping functions.
// ----------------------------------------------------------------------------
`default_nettype none

package pidaw_pkg;

  localparam int GAIN_W  = 24;                 // unsigned Q8.16 gains
  localparam int VAL_W   = 24;                 // signed Q8.16 target / sensed
  localparam int LIM_W   = 18;                 // signed Q2.16 limits, acc, drive
  localparam int CNT_W   = 32;                 // update step counter
  localparam int ERR_W   = VAL_W + 1;          // exact difference of two values
  localparam int PROD_W  = 2 * ERR_W;          // gain (zero-extended) times error
  localparam int FRAC_W  = 16;                 // Q16 fraction bits
  localparam int RND_W   = PROD_W - FRAC_W;    // product after dropping fraction
  localparam int SUM_W   = RND_W + 2;          // room for three-term sum
  localparam int CFG_W   = GAIN_W;             // widest register
  localparam int NUM_REG = 8;
  localparam int IDX_W   = $clog2(NUM_REG);

  localparam logic [GAIN_W-1:0]       PROP_GAIN_RST  = GAIN_W'(32768);
  localparam logic [GAIN_W-1:0]       INT_GAIN_RST   = GAIN_W'(762);
  localparam logic [GAIN_W-1:0]       DERIV_GAIN_RST = GAIN_W'(56361);
  localparam logic signed [LIM_W-1:0] OUT_UPPER_RST  = LIM_W'(62259);
  localparam logic signed [LIM_W-1:0] OUT_LOWER_RST  = LIM_W'(0);
  localparam logic signed [LIM_W-1:0] ACC_UPPER_RST  = LIM_W'(62259);
  localparam logic signed [LIM_W-1:0] ACC_LOWER_RST  = -LIM_W'(62259);

  typedef enum logic [IDX_W-1:0] {
    REG_PROP_GAIN   = 3'd0,
    REG_INT_GAIN_DT = 3'd1,
    REG_DERIV_GAIN  = 3'd2,
    REG_OUT_UPPER   = 3'd3,
    REG_OUT_LOWER   = 3'd4,
    REG_ACC_UPPER   = 3'd5,
    REG_ACC_LOWER   = 3'd6,
    REG_LOOP_ENABLE = 3'd7
  } cfg_reg_t;

  // Round half up: floor((v + 2^15) / 2^16)
  function automatic logic signed [RND_W-1:0] rnd_q16(input logic signed [PROD_W-1:0] v);
    logic signed [PROD_W-1:0] t;
    t = v + $signed(PROD_W'(1 << (FRAC_W - 1)));
    return t[PROD_W-1:FRAC_W];
  endfunction

  // Upper limit first, then lower limit; the lower limit wins if they cross
  function automatic logic signed [LIM_W-1:0] clamp_hl(input logic signed [SUM_W-1:0] v,
                                                       input logic signed [LIM_W-1:0] hi,
                                                       input logic signed [LIM_W-1:0] lo);
    logic signed [SUM_W-1:0] r;
    logic signed [SUM_W-1:0] hi_x;
    logic signed [SUM_W-1:0] lo_x;
    hi_x = SUM_W'(hi);
    lo_x = SUM_W'(lo);
    r = v;
    if (r > hi_x) r = hi_x;
    if (r < lo_x) r = lo_x;
    return r[LIM_W-1:0];
  endfunction

endpackage

`default_nettype wire

FILE: design/pid_controller_antiwindup.sv
// A request accepted into stage A reaches out_* when it leaves stage A; an output stall can hold it there.
// Throughput: one request per cycle; stall on the output backs up through two stages.
// The path limit is the gain multiply in stage A and the integral/sum/clamp in stage B.
// Reset (rst_n low, synchronous): loop state and counter go to zero, pipeline
// empties, configuration returns to its default gains and limits.
// ----------------------------------------------------------------------------
// pid_controller_antiwindup: fixed-point PID step with clamped integral
// Derivative on measurement, rectangular integral, clamped output, Q16 math.
// ----------------------------------------------------------------------------
`default_nettype none

module pid_controller_antiwindup
  import pidaw_pkg::*;
(
  input  wire logic                    clk,
  input  wire logic                    rst_n,
  // configuration write port
  input  wire logic                    cfg_we,
  input  wire logic [IDX_W-1:0]        cfg_index,
  input  wire logic [CFG_W-1:0]        cfg_wdata,
  // request channel
  input  wire logic                    in_valid,
  output logic                         in_stall,
  input  wire logic                    in_action,
  input  wire logic signed [VAL_W-1:0] in_target,
  input  wire logic signed [VAL_W-1:0] in_sensed,
  // result channel
  output logic                         out_valid,
  input  wire logic                    out_stall,
  output logic signed [LIM_W-1:0]      out_drive,
  output logic [CNT_W-1:0]             out_step_count
);

  // --------------------------------------------------------------------------
  // Configuration registers
  // --------------------------------------------------------------------------
  logic [GAIN_W-1:0]       prop_gain_r;
  logic [GAIN_W-1:0]       int_gain_dt_r;
  logic [GAIN_W-1:0]       deriv_gain_rate_r;
  logic signed [LIM_W-1:0] out_upper_r;
  logic signed [LIM_W-1:0] out_lower_r;
  logic signed [LIM_W-1:0] acc_upper_r;
  logic signed [LIM_W-1:0] acc_lower_r;
  logic                    loop_enable_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      prop_gain_r       <= PROP_GAIN_RST;
      int_gain_dt_r     <= INT_GAIN_RST;
      deriv_gain_rate_r <= DERIV_GAIN_RST;
      out_upper_r       <= OUT_UPPER_RST;
      out_lower_r       <= OUT_LOWER_RST;
      acc_upper_r       <= ACC_UPPER_RST;
      acc_lower_r       <= ACC_LOWER_RST;
      loop_enable_r     <= 1'b1;
    end else if (cfg_we) begin
      unique case (cfg_reg_t'(cfg_index))
        REG_PROP_GAIN:   prop_gain_r       <= cfg_wdata[GAIN_W-1:0];
        REG_INT_GAIN_DT: int_gain_dt_r     <= cfg_wdata[GAIN_W-1:0];
        REG_DERIV_GAIN:  deriv_gain_rate_r <= cfg_wdata[GAIN_W-1:0];
        REG_OUT_UPPER:   out_upper_r       <= cfg_wdata[LIM_W-1:0];
        REG_OUT_LOWER:   out_lower_r       <= cfg_wdata[LIM_W-1:0];
        REG_ACC_UPPER:   acc_upper_r       <= cfg_wdata[LIM_W-1:0];
        REG_ACC_LOWER:   acc_lower_r       <= cfg_wdata[LIM_W-1:0];
        REG_LOOP_ENABLE: loop_enable_r     <= cfg_wdata[0];
        default:         ;
      endcase
    end
  end

  // --------------------------------------------------------------------------
  // Pipeline handshake: each stage loads when it is empty or its successor
  // takes its content this cycle.
  // --------------------------------------------------------------------------
  logic a_valid_r;
  logic out_valid_r;
  logic b_ld;
  logic a_ld;
  logic in_acc;
  logic b_fire;

  assign b_ld     = !out_valid_r || !out_stall;
  assign a_ld     = !a_valid_r || b_ld;
  assign in_stall = !a_ld;
  assign in_acc   = in_valid && a_ld;
  assign b_fire   = a_valid_r && b_ld;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      a_valid_r   <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      if (a_ld) a_valid_r   <= in_valid;
      if (b_ld) out_valid_r <= a_valid_r;
    end
  end

  // --------------------------------------------------------------------------
  // Stage A: error, measurement step and the three gain products.
  // The previous measurement is tracked at accept time, so back-to-back
  // requests see the right history without waiting for stage B.
  // --------------------------------------------------------------------------
  logic signed [VAL_W-1:0]  last_sensed_r;
  logic signed [ERR_W-1:0]  err;
  logic signed [ERR_W-1:0]  meas_fall;     // last_sensed - sensed = -(sensed - last)
  logic signed [PROD_W-1:0] p_prod_nxt;
  logic signed [PROD_W-1:0] i_prod_nxt;
  logic signed [PROD_W-1:0] d_prod_nxt;
  logic signed [PROD_W-1:0] p_prod_r;
  logic signed [PROD_W-1:0] i_prod_r;
  logic signed [PROD_W-1:0] d_prod_r;
  logic                     a_action_r;

  always_comb begin
    err        = ERR_W'(in_target) - ERR_W'(in_sensed);
    meas_fall  = ERR_W'(last_sensed_r) - ERR_W'(in_sensed);
    // gains are unsigned: prepend a zero so the product is signed-correct
    p_prod_nxt = PROD_W'($signed({1'b0, prop_gain_r})) * PROD_W'(err);
    i_prod_nxt = PROD_W'($signed({1'b0, int_gain_dt_r})) * PROD_W'(err);
    d_prod_nxt = PROD_W'($signed({1'b0, deriv_gain_rate_r})) * PROD_W'(meas_fall);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      last_sensed_r <= '0;
    end else if (in_acc) begin
      if (in_action) begin
        last_sensed_r <= '0;
      end else if (loop_enable_r) begin
        last_sensed_r <= in_sensed;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (in_acc) begin
      a_action_r <= in_action;
      p_prod_r   <= p_prod_nxt;
      i_prod_r   <= i_prod_nxt;
      d_prod_r   <= d_prod_nxt;
    end
  end

  // --------------------------------------------------------------------------
  // Stage B: round, integrate, clamp, sum, clamp. The loop state registers
  // double as the result register: they change only when stage B fires.
  // --------------------------------------------------------------------------
  logic signed [LIM_W-1:0] acc_r;
  logic signed [LIM_W-1:0] last_drive_r;
  logic [CNT_W-1:0]        steps_r;
  logic signed [RND_W-1:0] p_term;
  logic signed [RND_W-1:0] i_term;
  logic signed [RND_W-1:0] d_term;
  logic signed [SUM_W-1:0] acc_sum;
  logic signed [LIM_W-1:0] acc_nxt;
  logic signed [SUM_W-1:0] out_sum;
  logic signed [LIM_W-1:0] drive_nxt;

  always_comb begin
    p_term    = rnd_q16(p_prod_r);
    i_term    = rnd_q16(i_prod_r);
    d_term    = rnd_q16(d_prod_r);
    acc_sum   = SUM_W'(acc_r) + SUM_W'(i_term);
    acc_nxt   = clamp_hl(acc_sum, acc_upper_r, acc_lower_r);
    out_sum   = SUM_W'(p_term) + SUM_W'(acc_nxt) + SUM_W'(d_term);
    drive_nxt = clamp_hl(out_sum, out_upper_r, out_lower_r);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      acc_r        <= '0;
      last_drive_r <= '0;
      steps_r      <= '0;
    end else if (b_fire) begin
      if (a_action_r) begin
        // clear: wipe loop state, whether or not the loop runs
        acc_r        <= '0;
        last_drive_r <= '0;
        steps_r      <= '0;
      end else if (loop_enable_r) begin
        acc_r        <= acc_nxt;
        last_drive_r <= drive_nxt;
        steps_r      <= steps_r + CNT_W'(1);
      end
      // disabled update: hold everything, repeat the last output
    end
  end

  assign out_valid      = out_valid_r;
  assign out_drive      = last_drive_r;
  assign out_step_count = steps_r;

  // --------------------------------------------------------------------------
  // Assertions
  // --------------------------------------------------------------------------
  // A clear request leaves a zero result behind it.
  a_clear_zero: assert property (@(posedge clk) disable iff (!rst_n)
    (b_fire && a_action_r) |=> (out_drive == '0 && out_step_count == '0))
    else $error("clear request did not zero the result");

  // A running update respects the output limits when they do not cross.
  a_drive_limits: assert property (@(posedge clk) disable iff (!rst_n)
    (b_fire && !a_action_r && loop_enable_r && (out_lower_r <= out_upper_r))
    |=> (out_drive <= $past(out_upper_r) && out_drive >= $past(out_lower_r)))
    else $error("drive outside output limits");

  // The integral stays inside its limits after a running update.
  a_acc_limits: assert property (@(posedge clk) disable iff (!rst_n)
    (b_fire && !a_action_r && loop_enable_r && (acc_lower_r <= acc_upper_r))
    |=> (acc_r <= $past(acc_upper_r) && acc_r >= $past(acc_lower_r)))
    else $error("integral outside its limits");

  // The input side only stalls while stage A holds a request it cannot pass on.
  a_stall_cause: assert property (@(posedge clk) disable iff (!rst_n)
    in_stall |-> (a_valid_r && out_valid_r && out_stall))
    else $error("input stalled without a blocked pipeline");

endmodule

`default_nettype wire
